[hdl/tscc_pkg.sv]
package tscc_pkg;

    // Register indexes on the configuration port
    localparam logic [0:0] REG_RESOLUTION = 1'b0;
    localparam logic [0:0] REG_FAHRENHEIT = 1'b1;

    // Resolution codes
    localparam logic [1:0] RES_9BIT  = 2'd0;
    localparam logic [1:0] RES_10BIT = 2'd1;
    localparam logic [1:0] RES_11BIT = 2'd2;
    localparam logic [1:0] RES_12BIT = 2'd3;

    // Scratchpad layout
    localparam logic [3:0] POS_TEMP_LSB = 4'd0;
    localparam logic [3:0] POS_TEMP_MSB = 4'd1;
    localparam logic [3:0] POS_CRC      = 4'd8;

    // Reflected CRC-8 polynomial
    localparam logic [7:0] CRC_POLY = 8'h8C;

    // Fahrenheit conversion: floor(raw*9/5) + 512 computed as
    // floor((raw*9 + 5*65536) / 5) - 65536 + 512, divide by 5 done as a
    // multiply by ceil(2^22/5) and a shift; exact for a dividend below 2^22.
    localparam logic [20:0] F_BIAS      = 21'd327680;
    localparam logic [19:0] DIV5_RECIP  = 20'd838861;
    localparam int          DIV5_SHIFT  = 22;
    localparam logic [17:0] F_OFFSET    = 18'd65024;

    typedef logic signed [16:0] temp_t;
    typedef logic signed [15:0] raw_t;

    // One finished scratchpad, handed from the front to the back
    typedef struct packed {
        raw_t raw;
        logic fahrenheit;
        logic crc_ok;
        logic blank;
    } frame_rec_t;

    // Low byte mask for a resolution code
    function automatic logic [7:0] res_mask(input logic [1:0] res);
        logic [7:0] m;
        case (res)
            RES_9BIT:  m = 8'hF8;
            RES_10BIT: m = 8'hFC;
            RES_11BIT: m = 8'hFE;
            RES_12BIT: m = 8'hFF;
            default:   m = 8'hFF;
        endcase
        return m;
    endfunction

    // One byte of the reflected CRC-8, LSB first
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] b);
        logic [7:0] c;
        logic       mix;
        c = crc_in;
        for (int k = 0; k < 8; k++)
        begin
            mix = c[0] ^ b[k];
            c   = {1'b0, c[7:1]};
            if (mix)
            begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

endpackage

[hdl/tscc_front.sv]
module tscc_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [0:0]          cfg_index,
    input  logic [1:0]          cfg_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          data_byte,
    input  logic                frame_start,
    input  logic                q_full,
    output logic                q_push,
    output tscc_pkg::frame_rec_t q_data
);
    import tscc_pkg::*;

    logic [1:0] resolution_reg;
    logic       fahrenheit_reg;
    logic [3:0] pos_reg,  pos_next;
    logic [7:0] crc_reg,  crc_next;
    logic       zero_reg, zero_next;
    logic [7:0] lsb_reg,  lsb_next;
    logic [7:0] msb_reg,  msb_next;

    logic       fire;
    logic [3:0] pos_eff;
    logic [7:0] crc_eff;
    logic       zero_eff;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            resolution_reg <= RES_12BIT;
            fahrenheit_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_RESOLUTION: resolution_reg <= cfg_data;
                REG_FAHRENHEIT: fahrenheit_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign in_ready = !q_full;
    assign fire     = in_valid && in_ready;

    // Frame start restarts the frame in the same cycle
    assign pos_eff  = frame_start ? 4'd0 : pos_reg;
    assign crc_eff  = frame_start ? 8'd0 : crc_reg;
    assign zero_eff = frame_start ? 1'b1 : zero_reg;

    // Byte classification and frame tracking
    always_comb
    begin
        pos_next  = pos_reg;
        crc_next  = crc_reg;
        zero_next = zero_reg;
        lsb_next  = lsb_reg;
        msb_next  = msb_reg;
        q_push    = 1'b0;
        if (fire)
        begin
            if (pos_eff < POS_CRC)
            begin
                if (pos_eff == POS_TEMP_LSB)
                begin
                    lsb_next = data_byte;
                end
                if (pos_eff == POS_TEMP_MSB)
                begin
                    msb_next = data_byte;
                end
                crc_next  = crc8_byte(crc_eff, data_byte);
                zero_next = zero_eff && (data_byte == 8'd0);
                pos_next  = pos_eff + 4'd1;
            end
            else
            begin
                q_push    = 1'b1;
                pos_next  = 4'd0;
                crc_next  = 8'd0;
                zero_next = 1'b1;
            end
        end
    end

    // Record for a finished frame
    always_comb
    begin
        q_data.raw        = raw_t'({msb_reg, lsb_reg & res_mask(resolution_reg)});
        q_data.fahrenheit = fahrenheit_reg;
        q_data.crc_ok     = (crc_eff == data_byte);
        q_data.blank      = zero_eff;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= 4'd0;
            crc_reg  <= 8'd0;
            zero_reg <= 1'b1;
            lsb_reg  <= 8'd0;
            msb_reg  <= 8'd0;
        end
        else
        begin
            pos_reg  <= pos_next;
            crc_reg  <= crc_next;
            zero_reg <= zero_next;
            lsb_reg  <= lsb_next;
            msb_reg  <= msb_next;
        end
    end

    // Position never runs past the check byte
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_CRC)
        else $error("byte position out of range");

    // A record only leaves on the check byte
    a_push_pos: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> (pos_eff == POS_CRC) && fire)
        else $error("push outside check byte");

    // A frame start byte is always byte 0, never the check byte
    a_start_no_push: assert property (@(posedge clk) disable iff (!rst_n)
        fire && frame_start |-> !q_push)
        else $error("push on frame start");

endmodule

[hdl/tscc_fifo.sv]
module tscc_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  tscc_pkg::frame_rec_t push_data,
    output logic                 full,
    input  logic                 pop,
    output logic                 empty,
    output tscc_pkg::frame_rec_t pop_data
);
    import tscc_pkg::*;

    frame_rec_t entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg,  count_next;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign pop_data = entry_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && empty))
        else $error("queue underflow");

    a_count_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd1) == (wr_ptr_reg != rd_ptr_reg))
        else $error("queue pointers disagree with count");

endmodule

[hdl/tscc_back.sv]
module tscc_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_empty,
    input  tscc_pkg::frame_rec_t q_data,
    output logic                 q_pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output tscc_pkg::temp_t      temperature,
    output logic                 crc_match,
    output logic                 blank_flag,
    output logic                 reading_valid
);
    import tscc_pkg::*;

    // Stage 1: biased dividend
    logic        s1_valid_reg;
    frame_rec_t  s1_rec_reg;
    logic [19:0] s1_num_reg;
    // Stage 2: reciprocal product
    logic        s2_valid_reg;
    frame_rec_t  s2_rec_reg;
    logic [39:0] s2_prod_reg;
    // Output register
    logic        o_valid_reg;
    temp_t       o_temp_reg;
    logic        o_crc_reg;
    logic        o_blank_reg;

    logic        o_ready, s2_ready, s1_ready;
    logic signed [20:0] raw_ext;
    logic signed [20:0] num_full;
    logic [17:0] quot;
    logic [17:0] fahr;
    temp_t       temp_calc;

    // Stall chain: a stage moves when the next one is free or moving
    assign o_ready  = !o_valid_reg || out_ready;
    assign s2_ready = !s2_valid_reg || o_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign q_pop    = !q_empty && s1_ready;

    // raw*9 + 5*65536, always positive and below 2^20
    assign raw_ext  = 21'(q_data.raw);
    assign num_full = (raw_ext <<< 3) + raw_ext + $signed(F_BIAS);

    // Quotient by 5 and offset back to Fahrenheit sixteenths
    assign quot = s2_prod_reg[39:DIV5_SHIFT];
    assign fahr = quot - F_OFFSET;
    assign temp_calc = s2_rec_reg.fahrenheit ? temp_t'(fahr[16:0])
                                             : temp_t'(s2_rec_reg.raw);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            o_valid_reg  <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= q_pop;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (o_ready)
            begin
                o_valid_reg <= s2_valid_reg;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            s1_rec_reg <= q_data;
            s1_num_reg <= num_full[19:0];
        end
        if (s2_ready && s1_valid_reg)
        begin
            s2_rec_reg  <= s1_rec_reg;
            s2_prod_reg <= s1_num_reg * DIV5_RECIP;
        end
        if (o_ready && s2_valid_reg)
        begin
            o_temp_reg  <= temp_calc;
            o_crc_reg   <= s2_rec_reg.crc_ok;
            o_blank_reg <= s2_rec_reg.blank;
        end
    end

    assign out_valid     = o_valid_reg;
    assign temperature   = o_temp_reg;
    assign crc_match     = o_crc_reg;
    assign blank_flag    = o_blank_reg;
    assign reading_valid = o_crc_reg && !o_blank_reg;

    // A stalled middle stage keeps its product
    a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg && !o_ready |=> s2_valid_reg && $stable(s2_prod_reg))
        else $error("stage 2 lost data under stall");

    // Dividend stays in the range where the reciprocal is exact
    a_num_range: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> s1_num_reg >= 20'd32768 && s1_num_reg <= 20'd622583)
        else $error("dividend out of range");

    // A waiting output item holds until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(temperature))
        else $error("output item changed under stall");

endmodule

[hdl/temp_sensor_scratchpad_check.sv]
// Scratchpad checker for a 1-Wire temperature sensor.
// Input channel (in_valid/in_ready): one scratchpad byte per item, bytes 0..8
// in bus order; frame_start marks byte 0 and drops any partial frame.
// Output channel (out_valid/out_ready): one item per complete frame, carrying
// the temperature in 1/16 degree (Celsius, or Fahrenheit when enabled), the
// CRC match, the all-zero flag and reading_valid.
// Configuration: cfg_wr_en with cfg_index 0 writes resolution, index 1 the
// Fahrenheit enable; write only while the block is idle.
// Throughput: one byte per cycle while the queue is not full. The CRC and byte
// classification are combinational in the front end; each finished frame
// enters a two-entry queue, then passes the dividend stage, the divide-by-5
// multiply stage and the output register.
// Stalls: out_ready low holds the output register; the back-end pipeline and
// then the queue fill, and in_ready drops only when the queue is full.
// Reset: resolution returns to 12 bit, Celsius mode, frame counting restarts
// at byte 0 and all pending results are discarded.
module temp_sensor_scratchpad_check (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_wr_en,
    input  logic [0:0]      cfg_index,
    input  logic [1:0]      cfg_data,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [7:0]      data_byte,
    input  logic            frame_start,
    output logic            out_valid,
    input  logic            out_ready,
    output tscc_pkg::temp_t temperature,
    output logic            crc_match,
    output logic            blank_flag,
    output logic            reading_valid
);
    import tscc_pkg::*;

    logic       q_push, q_full, q_pop, q_empty;
    frame_rec_t q_wdata, q_rdata;

    tscc_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .data_byte   (data_byte),
        .frame_start (frame_start),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_data      (q_wdata)
    );

    tscc_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_wdata),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .pop_data  (q_rdata)
    );

    tscc_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .q_data        (q_rdata),
        .q_pop         (q_pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .temperature   (temperature),
        .crc_match     (crc_match),
        .blank_flag    (blank_flag),
        .reading_valid (reading_valid)
    );

endmodule

[bench/temp_sensor_scratchpad_check_tb.sv]
`timescale 1ns / 100ps

module temp_sensor_scratchpad_check_tb;

    import tscc_pkg::*;

    localparam logic [7:0] CRC_REFLECTED = 8'h8C;
    localparam int         CYCLE_LIMIT   = 400000;
    localparam int         RANDOM_ITEMS  = 1300;
    localparam int         PHASES        = 8;
    localparam int         DRAIN_CYCLES  = 8;

    // settings walked by the random phases, extremes included
    localparam logic [1:0] PHASE_RES [0:PHASES-1] = '{RES_12BIT, RES_9BIT, RES_10BIT, RES_11BIT,
                                                     RES_9BIT, RES_12BIT, RES_11BIT, RES_10BIT};
    localparam logic       PHASE_FAHR [0:PHASES-1] = '{1'b1, 1'b0, 1'b1, 1'b0,
                                                      1'b1, 1'b0, 1'b1, 1'b0};

    typedef struct packed {
        temp_t temperature;
        logic  crc_match;
        logic  blank_flag;
        logic  reading_valid;
    } reading_t;

    typedef enum logic [1:0] {ROW_BYTE, ROW_CRC, ROW_REG} row_kind_t;

    typedef struct packed {
        row_kind_t  kind;
        logic [7:0] value;
        logic       start;
        logic [0:0] reg_sel;
        logic       typed;
        reading_t   want;
    } pad_row_t;

    logic            clk         = 1'b0;
    logic            rst_n       = 1'b0;
    logic            cfg_wr_en   = 1'b0;
    logic [0:0]      cfg_index   = REG_RESOLUTION;
    logic [1:0]      cfg_data    = 2'b00;
    logic            in_valid    = 1'b0;
    logic            in_ready;
    logic [7:0]      data_byte   = 8'h00;
    logic            frame_start = 1'b0;
    logic            out_valid;
    logic            out_ready   = 1'b0;
    temp_t           temperature;
    logic            crc_match;
    logic            blank_flag;
    logic            reading_valid;

    // scratchpad tracker and register copies
    logic [3:0]      pad_pos;
    logic [7:0]      pad_crc;
    logic            pad_zero;
    logic [7:0]      pad_lo;
    logic [7:0]      pad_hi;
    logic [1:0]      cur_res;
    logic            cur_fahr;

    reading_t        pending_readings[$];
    pad_row_t        script_rows[$];
    int              mismatch_count = 0;
    int              cycle_count    = 0;
    int              bytes_sent     = 0;
    int              gap_pct        = 25;
    bit              no_idle        = 1'b0;
    int              ready_hold     = 0;

    temp_sensor_scratchpad_check dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .data_byte     (data_byte),
        .frame_start   (frame_start),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .temperature   (temperature),
        .crc_match     (crc_match),
        .blank_flag    (blank_flag),
        .reading_valid (reading_valid)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Advance the scratchpad by one byte; returns 1 with the reading after byte 8
    function automatic bit pad_step(input logic [7:0] b, input logic s, output reading_t r);
        logic [7:0] mask;
        raw_t       raw;
        int         scaled;
        r = '0;
        if (s)
        begin
            pad_pos  = 4'd0;
            pad_crc  = 8'h00;
            pad_zero = 1'b1;
        end
        if (pad_pos < POS_CRC)
        begin
            if (pad_pos == POS_TEMP_LSB)
                pad_lo = b;
            else if (pad_pos == POS_TEMP_MSB)
                pad_hi = b;
            // reflected CRC, LSB of the byte first
            for (int k = 0; k < 8; k++)
            begin
                if (pad_crc[0] ^ b[k])
                    pad_crc = (pad_crc >> 1) ^ CRC_REFLECTED;
                else
                    pad_crc = pad_crc >> 1;
            end
            if (b != 8'h00)
                pad_zero = 1'b0;
            pad_pos = pad_pos + 4'd1;
            return 1'b0;
        end
        case (cur_res)
            RES_9BIT:  mask = 8'hF8;
            RES_10BIT: mask = 8'hFC;
            RES_11BIT: mask = 8'hFE;
            default:   mask = 8'hFF;
        endcase
        raw = {pad_hi, pad_lo & mask};
        // floor(raw * 9 / 5) + 512, dividend kept non-negative
        if (cur_fahr)
            scaled = (int'(raw) * 9 + 5 * 65536) / 5 - 65536 + 512;
        else
            scaled = int'(raw);
        r.temperature   = scaled[16:0];
        r.crc_match     = (pad_crc == b);
        r.blank_flag    = pad_zero;
        r.reading_valid = r.crc_match & ~pad_zero;
        pad_pos  = 4'd0;
        pad_crc  = 8'h00;
        pad_zero = 1'b1;
        return 1'b1;
    endfunction

    function automatic void add_row(input row_kind_t kind, input logic [7:0] value,
                                    input logic start, input logic [0:0] reg_sel,
                                    input logic typed, input int temp, input logic crc_ok,
                                    input logic blank, input logic ok);
        pad_row_t row;
        row.kind               = kind;
        row.value              = value;
        row.start              = start;
        row.reg_sel            = reg_sel;
        row.typed              = typed;
        row.want.temperature   = temp[16:0];
        row.want.crc_match     = crc_ok;
        row.want.blank_flag    = blank;
        row.want.reading_valid = ok;
        script_rows.push_back(row);
    endfunction

    // Offer one byte, with an optional idle burst ahead of it
    task automatic send_byte(input logic [7:0] b, input logic s, input logic typed,
                             input reading_t want);
        reading_t got;
        @(negedge clk);
        if (!no_idle && gap_pct != 0 && $urandom_range(1, 100) <= gap_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
        end
        in_valid    <= 1'b1;
        data_byte   <= b;
        frame_start <= s;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (pad_step(b, s, got))
            pending_readings.push_back(typed ? want : got);
        bytes_sent++;
    endtask

    // Let the block go idle, then write one register
    task automatic write_reg(input logic [0:0] idx, input logic [1:0] val);
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_readings.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_RESOLUTION)
            cur_res = val;
        else
            cur_fahr = val[0];
    endtask

    // Mostly well-formed scratchpads; some cut short, unsynced or restarted
    task automatic send_random_frame();
        logic [7:0] pad [0:8];
        int         cut;
        int         stray;
        logic       blank;
        logic       s;
        blank = ($urandom_range(0, 11) == 0);
        for (int k = 0; k < 9; k++)
            pad[k] = blank ? 8'h00 : 8'($urandom_range(0, 255));
        if (!blank && $urandom_range(0, 7) == 0)
        begin
            pad[0] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            pad[1] = $urandom_range(0, 1) ? 8'h7F : 8'h80;
        end
        cut     = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 8) : 9;
        stray   = ($urandom_range(0, 24) == 0) ? $urandom_range(1, 8) : 0;
        gap_pct = ($urandom_range(0, 2) == 0) ? 0 : 25;
        for (int k = 0; k < cut; k++)
        begin
            if (k == 8 && $urandom_range(0, 3) != 0)
                pad[8] = pad_crc;
            s = (k == 0) ? ($urandom_range(0, 7) != 0) : (k == stray);
            send_byte(pad[k], s, 1'b0, '0);
        end
    endtask

    // Receiver: random stall bursts between runs of ready
    always @(negedge clk)
    begin
        if (no_idle)
            out_ready <= 1'b1;
        else if (ready_hold != 0)
            ready_hold <= ready_hold - 1;
        else if ($urandom_range(0, 3) == 0)
        begin
            out_ready  <= 1'b0;
            ready_hold <= $urandom_range(0, 11);
        end
        else
        begin
            out_ready  <= 1'b1;
            ready_hold <= $urandom_range(0, 19);
        end
    end

    // Result checker
    always @(posedge clk)
    begin
        reading_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_readings.size() == 0)
            begin
                $error("unexpected item: temperature %0d crc_match %0b blank_flag %0b",
                       temperature, crc_match, blank_flag);
                mismatch_count++;
            end
            else
            begin
                want = pending_readings.pop_front();
                if (temperature !== want.temperature)
                begin
                    $error("temperature: expected %0d, got %0d", want.temperature, temperature);
                    mismatch_count++;
                end
                if (crc_match !== want.crc_match)
                begin
                    $error("crc_match: expected %0b, got %0b", want.crc_match, crc_match);
                    mismatch_count++;
                end
                if (blank_flag !== want.blank_flag)
                begin
                    $error("blank_flag: expected %0b, got %0b", want.blank_flag, blank_flag);
                    mismatch_count++;
                end
                if (reading_valid !== want.reading_valid)
                begin
                    $error("reading_valid: expected %0b, got %0b",
                           want.reading_valid, reading_valid);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("temp_sensor_scratchpad_check_tb: done, errors");
            $finish;
        end
    end

    initial
    begin
        pad_row_t row;
        logic [7:0] b;
        int target;

        pad_pos  = 4'd0;
        pad_crc  = 8'h00;
        pad_zero = 1'b1;
        pad_lo   = 8'h00;
        pad_hi   = 8'h00;
        cur_res  = RES_12BIT;
        cur_fahr = 1'b0;

        // 12 bit Celsius, largest raw word, good CRC
        add_row(ROW_BYTE, 8'hFF, 1'b1, REG_RESOLUTION, 1'b0, 0, 1'b0, 1'b0, 1'b0);
        add_row(ROW_BYTE, 8'h7F, 1'b0, REG_RESOLUTION, 1'b0, 0, 1'b0, 1'b0, 1'b0);
        add_row(ROW_BYTE, 8'h4B, 1'b0, REG_RESOLUTION, 1'b0, 0, 1'b0, 1'b0, 1'b0);
        add_row(ROW_BYTE, 8'h46, 1'b0, REG_RESOLUTION, 1'b0, 0, 1'b0, 1'b0, 1'b0);
        add_row(ROW_BYTE, 8'h7F, 1'b0, REG_RESOLUTION, 1'b0, 0, 1'b0, 1'b0, 1'b0);
        add_row(ROW_BYTE, 8'hFF, 1'b0, REG_RESOLUTION, 1'b0, 0, 1'b0, 1'b0, 1'b0);
        add_row(ROW_BYTE, 8'h0C, 1'b0, REG_RESOLUTION, 1'b0, 0, 1'b0, 1'b0, 1'b0);
        add_row(ROW_BYTE, 8'h10, 1'b0, REG_RESOLUTION, 1'b0, 0, 1'b0, 1'b0, 1'b0);
        add_row(ROW_CRC,  8'h00, 1'b0, REG_RESOLUTION, 1'b1, 32767, 1'b1, 1'b0, 1'b1);
        // 9 bit Fahrenheit
        add_row(ROW_REG,  {6'd0, RES_9BIT}, 1'b0, REG_RESOLUTION, 1'b0, 0, 1'b0, 1'b0, 1'b0);
        add_row(ROW_REG,  8'h01, 1'b0, REG_FAHRENHEIT, 1'b0, 0, 1'b0, 1'b0, 1'b0);
        // no frame start: counting rolls over to byte 0; low bits masked, most negative word
        add_row(ROW_BYTE, 8'h07, 1'b0, REG_RESOLUTION, 1'b0, 0, 1'b0, 1'b0, 1'b0);
        add_row(ROW_BYTE, 8'h80, 1'b0, REG_RESOLUTION, 1'b0, 0, 1'b0, 1'b0, 1'b0);
        add_row(ROW_BYTE, 8'h4B, 1'b0, REG_RESOLUTION, 1'b0, 0, 1'b0, 1'b0, 1'b0);
        add_row(ROW_BYTE, 8'h46, 1'b0, REG_RESOLUTION, 1'b0, 0, 1'b0, 1'b0, 1'b0);
        add_row(ROW_BYTE, 8'h1F, 1'b0, REG_RESOLUTION, 1'b0, 0, 1'b0, 1'b0, 1'b0);
        add_row(ROW_BYTE, 8'hFF, 1'b0, REG_RESOLUTION, 1'b0, 0, 1'b0, 1'b0, 1'b0);
        add_row(ROW_BYTE, 8'h0C, 1'b0, REG_RESOLUTION, 1'b0, 0, 1'b0, 1'b0, 1'b0);
        add_row(ROW_BYTE, 8'h10, 1'b0, REG_RESOLUTION, 1'b0, 0, 1'b0, 1'b0, 1'b0);
        add_row(ROW_CRC,  8'h00, 1'b0, REG_RESOLUTION, 1'b1, -58471, 1'b1, 1'b0, 1'b1);
        // partial frame, then dropped by a frame start
        add_row(ROW_BYTE, 8'h50, 1'b1, REG_RESOLUTION, 1'b0, 0, 1'b0, 1'b0, 1'b0);
        add_row(ROW_BYTE, 8'h05, 1'b0, REG_RESOLUTION, 1'b0, 0, 1'b0, 1'b0, 1'b0);
        add_row(ROW_BYTE, 8'h4B, 1'b0, REG_RESOLUTION, 1'b0, 0, 1'b0, 1'b0, 1'b0);
        // blank pad; mode switched mid-frame, the ninth byte decides
        add_row(ROW_BYTE, 8'h00, 1'b1, REG_RESOLUTION, 1'b0, 0, 1'b0, 1'b0, 1'b0);
        add_row(ROW_BYTE, 8'h00, 1'b0, REG_RESOLUTION, 1'b0, 0, 1'b0, 1'b0, 1'b0);
        add_row(ROW_BYTE, 8'h00, 1'b0, REG_RESOLUTION, 1'b0, 0, 1'b0, 1'b0, 1'b0);
        add_row(ROW_BYTE, 8'h00, 1'b0, REG_RESOLUTION, 1'b0, 0, 1'b0, 1'b0, 1'b0);
        add_row(ROW_REG,  8'h00, 1'b0, REG_FAHRENHEIT, 1'b0, 0, 1'b0, 1'b0, 1'b0);
        add_row(ROW_BYTE, 8'h00, 1'b0, REG_RESOLUTION, 1'b0, 0, 1'b0, 1'b0, 1'b0);
        add_row(ROW_BYTE, 8'h00, 1'b0, REG_RESOLUTION, 1'b0, 0, 1'b0, 1'b0, 1'b0);
        add_row(ROW_BYTE, 8'h00, 1'b0, REG_RESOLUTION, 1'b0, 0, 1'b0, 1'b0, 1'b0);
        add_row(ROW_BYTE, 8'h00, 1'b0, REG_RESOLUTION, 1'b0, 0, 1'b0, 1'b0, 1'b0);
        add_row(ROW_BYTE, 8'h00, 1'b0, REG_RESOLUTION, 1'b1, 0, 1'b1, 1'b1, 1'b0);

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        // directed part
        for (int i = 0; i < script_rows.size(); i++)
        begin
            row = script_rows[i];
            if (row.kind == ROW_REG)
                write_reg(row.reg_sel, row.value[1:0]);
            else
            begin
                b = (row.kind == ROW_CRC) ? pad_crc : row.value;
                send_byte(b, row.start, row.typed, row.want);
            end
        end

        // random phases, one register setting each; the last one without idling
        for (int p = 0; p < PHASES; p++)
        begin
            write_reg(REG_RESOLUTION, PHASE_RES[p]);
            write_reg(REG_FAHRENHEIT, {1'b0, PHASE_FAHR[p]});
            no_idle = (p == PHASES - 1);
            target  = bytes_sent + RANDOM_ITEMS / PHASES;
            while (bytes_sent < target)
                send_random_frame();
        end

        // drain
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_readings.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("temp_sensor_scratchpad_check_tb: done, clean");
        else
            $display("temp_sensor_scratchpad_check_tb: done, errors");
        $finish;
    end

endmodule
